// ----- hdl/bqp_pkg.sv -----
// Shared types and constants for the boolean query infix-to-postfix unit.
// Used by bqp_cell, bqp_stack and boolean_query_infix_to_postfix_unit.
package bqp_pkg;

    localparam int STACK_DEPTH = 16;

    // Byte codes with a meaning of their own
    localparam logic [7:0] CH_SPACE     = 8'd32;
    localparam logic [7:0] CH_QUOTE     = 8'd34;
    localparam logic [7:0] CH_OPER_LO_A = 8'd35;
    localparam logic [7:0] CH_OPER_HI_A = 8'd37;
    localparam logic [7:0] CH_AMP       = 8'd38;
    localparam logic [7:0] CH_OPER_LO_B = 8'd39;
    localparam logic [7:0] CH_OPEN      = 8'd40;
    localparam logic [7:0] CH_CLOSE     = 8'd41;
    localparam logic [7:0] CH_OPER_HI_B = 8'd122;
    localparam logic [7:0] CH_BAR       = 8'd124;

    typedef enum logic [1:0] {
        OP_PAREN = 2'd0,
        OP_AND   = 2'd2,
        OP_OR    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        K_CHAR = 3'd0,
        K_END  = 3'd1,
        K_AND  = 3'd2,
        K_OR   = 3'd3,
        K_DONE = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_EXTRA_CLOSE = 3'd1,
        ST_ILLEGAL     = 3'd2,
        ST_EXTRA_OPEN  = 3'd3,
        ST_OVERFLOW    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ACT_AND,
        ACT_OR,
        ACT_CLOSE,
        ACT_FINAL
    } act_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAKE,
        S_AFTER,
        S_FLUSH,
        S_POP,
        S_PUSH,
        S_DONE
    } state_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } cell_t;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
        op_t  code;
    } stk_cmd_t;

    typedef struct packed {
        logic top_valid;
        op_t  top_op;
        logic next_valid;
        logic full;
    } stk_stat_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] ch;
        status_t    st;
    } tok_t;

endpackage

// ----- hdl/bqp_cell.sv -----
// One entry of the shifting operator stack.
// Depends on bqp_pkg for cell_t and stk_cmd_t.
module bqp_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head,
    input  bqp_pkg::stk_cmd_t cmd,
    input  bqp_pkg::cell_t    above,
    input  bqp_pkg::cell_t    below,
    output bqp_pkg::cell_t    q
);
    import bqp_pkg::*;

    cell_t cell_reg;
    cell_t cell_next;

    always_comb
    begin
        cell_next = cell_reg;
        if (cmd.clear)
        begin
            cell_next.valid = head;
            cell_next.op    = OP_PAREN;
        end
        else if (cmd.push)
        begin
            cell_next = above;
        end
        else if (cmd.pop)
        begin
            cell_next = below;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg.valid <= head;
            cell_reg.op    <= OP_PAREN;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

    assign q = cell_reg;

endmodule

// ----- hdl/bqp_stack.sv -----
// Operator stack built as a row of bqp_cell entries; the top sits in cell 0.
// Depends on bqp_pkg and bqp_cell.
module bqp_stack (
    input  logic               clk,
    input  logic               rst_n,
    input  bqp_pkg::stk_cmd_t  cmd,
    output bqp_pkg::stk_stat_t stat
);
    import bqp_pkg::*;

    cell_t                  stage [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] valid_vec;
    logic [STACK_DEPTH-1:0] valid_inc;

    genvar i;
    generate
        for (i = 0; i < STACK_DEPTH; i++)
        begin : g_cell
            cell_t above_c;
            cell_t below_c;

            if (i == 0)
            begin : g_top
                assign above_c = '{valid: 1'b1, op: cmd.code};
            end
            else
            begin : g_mid
                assign above_c = stage[i-1];
            end

            if (i == STACK_DEPTH - 1)
            begin : g_bot
                assign below_c = '{valid: 1'b0, op: OP_PAREN};
            end
            else
            begin : g_up
                assign below_c = stage[i+1];
            end

            bqp_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .head  (i == 0),
                .cmd   (cmd),
                .above (above_c),
                .below (below_c),
                .q     (stage[i])
            );

            assign valid_vec[i] = stage[i].valid;
        end
    endgenerate

    assign stat.top_valid  = stage[0].valid;
    assign stat.top_op     = stage[0].op;
    assign stat.next_valid = stage[1].valid;
    assign stat.full       = stage[STACK_DEPTH-1].valid;

    assign valid_inc = valid_vec + 1'b1;

    // Filled entries must form one run starting at the top
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_inc & valid_vec) == '0)
        else $error("stack entries not contiguous");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> !stat.full)
        else $error("push onto full stack");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (stat.top_valid && !cmd.push))
        else $error("pop from empty stack or together with push");

endmodule

// ----- hdl/boolean_query_infix_to_postfix_unit.sv -----
// Top level of the boolean query infix-to-postfix unit: control sequencer,
// token hold and output registers. Depends on bqp_pkg and bqp_stack.
//
// Takes one byte of a boolean search expression per item and sends out postfix
// tokens, one per cycle at most. The byte marked end_of_expr adds the implicit
// close parenthesis and the done item; an error adds its own done item. The
// sequencer emits at most one token and does at most one stack step per cycle,
// unless output stall holds it, on a stack of STACK_DEPTH shifting cells. The
// final token of a byte is held until the sequencer knows the run is over, so
// it leaves the hold register overlapped with the next byte. Output stall only
// slows the sequencer; no token is dropped. No clearing pass follows reset.
module boolean_query_infix_to_postfix_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_code,
    input  logic       end_of_expr,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] token_kind,
    output logic [7:0] operand_char,
    output logic [2:0] status,
    output logic       last_of_run
);
    import bqp_pkg::*;

    typedef enum logic [2:0] {
        C_OPEN,
        C_CLOSE,
        C_QUOTE,
        C_AMP,
        C_BAR,
        C_SPACE,
        C_OPERAND,
        C_BAD
    } class_t;

    state_t     state_reg, state_next;
    act_t       act_reg, act_next;
    status_t    status_reg, status_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       inside_quote_reg, inside_quote_next;
    logic       operand_open_reg, operand_open_next;
    logic       half_and_reg, half_and_next;
    logic       half_or_reg, half_or_next;
    logic       error_latched_reg, error_latched_next;

    logic       hold_valid_reg;
    tok_t       hold_reg;
    logic       out_valid_reg;
    tok_t       out_reg;
    logic       out_last_reg;

    stk_cmd_t   stk_cmd;
    stk_stat_t  stk_stat;
    class_t     byte_class;
    tok_t       tok;
    logic       emit_req;
    logic       emit_ok;
    logic       blocked;
    logic       out_free;
    logic       accept;
    logic       drain;
    logic       clear_all;
    logic       top_is_op;
    state_t     after_st;

    bqp_stack u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (stk_cmd),
        .stat  (stk_stat)
    );

    always_comb
    begin
        if (byte_reg == CH_OPEN)
            byte_class = C_OPEN;
        else if (byte_reg == CH_CLOSE)
            byte_class = C_CLOSE;
        else if (byte_reg == CH_QUOTE)
            byte_class = C_QUOTE;
        else if (byte_reg == CH_AMP)
            byte_class = C_AMP;
        else if (byte_reg == CH_BAR)
            byte_class = C_BAR;
        else if (byte_reg == CH_SPACE)
            byte_class = C_SPACE;
        else if ((byte_reg >= CH_OPER_LO_B && byte_reg <= CH_OPER_HI_B)
                 || (byte_reg >= CH_OPER_LO_A && byte_reg <= CH_OPER_HI_A))
            byte_class = C_OPERAND;
        else
            byte_class = C_BAD;
    end

    assign top_is_op = stk_stat.top_valid && (stk_stat.top_op != OP_PAREN);
    assign after_st  = last_reg ? S_AFTER : S_IDLE;
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit_ok   = !hold_valid_reg || out_free;
    assign blocked   = emit_req && !emit_ok;
    assign in_stall  = (state_reg != S_IDLE) || (hold_valid_reg && !out_free);
    assign accept    = in_valid && !in_stall;
    assign drain     = (state_reg == S_IDLE) && hold_valid_reg && out_free;

    // Which states put a token into the hold register this cycle
    always_comb
    begin
        emit_req = 1'b0;
        unique case (state_reg)
            S_TAKE:
            begin
                if (!error_latched_reg)
                begin
                    if (inside_quote_reg)
                        emit_req = (byte_reg != CH_QUOTE);
                    else if (!half_and_reg && !half_or_reg)
                        emit_req = (byte_class == C_OPERAND);
                end
            end
            S_FLUSH: emit_req = operand_open_reg;
            S_POP:   emit_req = top_is_op;
            S_DONE:  emit_req = 1'b1;
            default: emit_req = 1'b0;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_TAKE;
            end
            S_TAKE:
            begin
                if (error_latched_reg)
                    state_next = S_IDLE;
                else if (inside_quote_reg)
                    state_next = (byte_reg == CH_QUOTE) ? S_AFTER : after_st;
                else if (half_and_reg)
                    state_next = (byte_reg != CH_AMP) ? S_DONE : S_FLUSH;
                else if (half_or_reg)
                    state_next = (byte_reg != CH_BAR) ? S_DONE : S_FLUSH;
                else
                begin
                    case (byte_class)
                        C_OPEN:  state_next = stk_stat.full ? S_DONE : after_st;
                        C_CLOSE: state_next = S_FLUSH;
                        C_BAD:   state_next = S_DONE;
                        default: state_next = after_st;
                    endcase
                end
            end
            S_AFTER:
            begin
                if (!last_reg)
                    state_next = S_IDLE;
                else if (inside_quote_reg || half_and_reg || half_or_reg)
                    state_next = S_DONE;
                else
                    state_next = S_FLUSH;
            end
            S_FLUSH:
            begin
                state_next = (act_reg == ACT_AND) ? S_PUSH : S_POP;
            end
            S_POP:
            begin
                if (act_reg == ACT_OR)
                    state_next = top_is_op ? S_POP : S_PUSH;
                else if (!stk_stat.top_valid)
                    state_next = S_DONE;
                else if (stk_stat.top_op == OP_PAREN)
                    state_next = (act_reg == ACT_FINAL) ? S_DONE : after_st;
                else
                    state_next = S_POP;
            end
            S_PUSH:  state_next = stk_stat.full ? S_DONE : after_st;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        if (blocked)
            state_next = state_reg;
    end

    // Datapath controls, flags and the token to emit
    always_comb
    begin
        act_next           = act_reg;
        status_next        = status_reg;
        inside_quote_next  = inside_quote_reg;
        operand_open_next  = operand_open_reg;
        half_and_next      = half_and_reg;
        half_or_next       = half_or_reg;
        error_latched_next = error_latched_reg;
        clear_all          = 1'b0;
        stk_cmd            = '{clear: 1'b0, push: 1'b0, pop: 1'b0, code: OP_PAREN};
        tok                = '{kind: K_CHAR, ch: 8'd0, st: ST_OK};

        unique case (state_reg)
            S_IDLE:
            begin
                status_next = ST_OK;
            end
            S_TAKE:
            begin
                if (error_latched_reg)
                begin
                    clear_all = last_reg;
                end
                else if (inside_quote_reg)
                begin
                    if (byte_reg == CH_QUOTE)
                        inside_quote_next = 1'b0;
                    else
                    begin
                        tok.ch            = byte_reg;
                        operand_open_next = 1'b1;
                    end
                end
                else if (half_and_reg)
                begin
                    if (byte_reg != CH_AMP)
                        status_next = ST_ILLEGAL;
                    else
                    begin
                        half_and_next = 1'b0;
                        act_next      = ACT_AND;
                    end
                end
                else if (half_or_reg)
                begin
                    if (byte_reg != CH_BAR)
                        status_next = ST_ILLEGAL;
                    else
                    begin
                        half_or_next = 1'b0;
                        act_next     = ACT_OR;
                    end
                end
                else
                begin
                    case (byte_class)
                        C_OPEN:
                        begin
                            if (stk_stat.full)
                                status_next = ST_OVERFLOW;
                            else
                            begin
                                stk_cmd.push = 1'b1;
                                stk_cmd.code = OP_PAREN;
                            end
                        end
                        C_CLOSE:   act_next          = ACT_CLOSE;
                        C_QUOTE:   inside_quote_next = 1'b1;
                        C_AMP:     half_and_next     = 1'b1;
                        C_BAR:     half_or_next      = 1'b1;
                        C_SPACE:   status_next       = ST_OK;
                        C_OPERAND:
                        begin
                            tok.ch            = byte_reg;
                            operand_open_next = 1'b1;
                        end
                        default:   status_next       = ST_ILLEGAL;
                    endcase
                end
            end
            S_AFTER:
            begin
                if (last_reg)
                begin
                    if (inside_quote_reg)
                        status_next = ST_EXTRA_OPEN;
                    else if (half_and_reg || half_or_reg)
                        status_next = ST_ILLEGAL;
                    else
                        act_next = ACT_FINAL;
                end
            end
            S_FLUSH:
            begin
                tok.kind          = K_END;
                operand_open_next = 1'b0;
            end
            S_POP:
            begin
                tok.kind = kind_t'({1'b0, stk_stat.top_op});
                if (act_reg == ACT_OR)
                begin
                    stk_cmd.pop = top_is_op;
                end
                else if (!stk_stat.top_valid)
                begin
                    status_next = ST_EXTRA_CLOSE;
                end
                else
                begin
                    stk_cmd.pop = 1'b1;
                    // Matching paren of the implicit outer pair: stack must empty
                    if (stk_stat.top_op == OP_PAREN && act_reg == ACT_FINAL)
                        status_next = stk_stat.next_valid ? ST_EXTRA_OPEN : ST_OK;
                end
            end
            S_PUSH:
            begin
                if (stk_stat.full)
                    status_next = ST_OVERFLOW;
                else
                begin
                    stk_cmd.push = 1'b1;
                    stk_cmd.code = (act_reg == ACT_AND) ? OP_AND : OP_OR;
                end
            end
            S_DONE:
            begin
                tok.kind = K_DONE;
                tok.st   = status_reg;
                if (last_reg)
                    clear_all = 1'b1;
                else
                    error_latched_next = 1'b1;
            end
            default:
            begin
                status_next = status_reg;
            end
        endcase

        if (clear_all)
        begin
            stk_cmd.clear      = 1'b1;
            inside_quote_next  = 1'b0;
            operand_open_next  = 1'b0;
            half_and_next      = 1'b0;
            half_or_next       = 1'b0;
            error_latched_next = 1'b0;
        end

        // Hold everything while the token cannot be placed
        if (blocked)
        begin
            act_next           = act_reg;
            status_next        = status_reg;
            inside_quote_next  = inside_quote_reg;
            operand_open_next  = operand_open_reg;
            half_and_next      = half_and_reg;
            half_or_next       = half_or_reg;
            error_latched_next = error_latched_reg;
            stk_cmd            = '{clear: 1'b0, push: 1'b0, pop: 1'b0, code: OP_PAREN};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            act_reg           <= ACT_AND;
            status_reg        <= ST_OK;
            inside_quote_reg  <= 1'b0;
            operand_open_reg  <= 1'b0;
            half_and_reg      <= 1'b0;
            half_or_reg       <= 1'b0;
            error_latched_reg <= 1'b0;
            hold_valid_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            act_reg           <= act_next;
            status_reg        <= status_next;
            inside_quote_reg  <= inside_quote_next;
            operand_open_reg  <= operand_open_next;
            half_and_reg      <= half_and_next;
            half_or_reg       <= half_or_next;
            error_latched_reg <= error_latched_next;

            if (emit_req && emit_ok)
                hold_valid_reg <= 1'b1;
            else if (drain)
                hold_valid_reg <= 1'b0;

            if ((emit_req && emit_ok && hold_valid_reg) || drain)
                out_valid_reg <= 1'b1;
            else if (out_free)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= char_code;
            last_reg <= end_of_expr;
        end
        if (emit_req && emit_ok)
            hold_reg <= tok;
        // A token leaves the hold as last of its run only when drained from idle
        if (emit_req && emit_ok && hold_valid_reg)
        begin
            out_reg      <= hold_reg;
            out_last_reg <= 1'b0;
        end
        else if (drain)
        begin
            out_reg      <= hold_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign token_kind   = out_reg.kind;
    assign operand_char = out_reg.ch;
    assign status       = out_reg.st;
    assign last_of_run  = out_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        blocked |=> (state_reg == $past(state_reg)))
        else $error("sequencer moved while token was blocked");

    assert property (@(posedge clk) disable iff (!rst_n)
        (emit_req && emit_ok && hold_valid_reg) |-> out_free)
        else $error("hold moved into a busy output register");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !blocked && !last_reg) |=> error_latched_reg)
        else $error("error not latched after early done");

endmodule

// ----- test/boolean_query_infix_to_postfix_unit_test.sv -----
// Testbench for boolean_query_infix_to_postfix_unit: sends boolean query text byte by
// byte and checks every postfix token against a shunting-yard predictor kept here.
// Depends on bqp_pkg and the unit's RTL under hdl.
module boolean_query_infix_to_postfix_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bqp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 150;

    typedef struct {
        kind_t      kind;
        logic [7:0] ch;
        status_t    st;
        logic       last;
    } token_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] char_code;
    logic       end_of_expr;
    logic       out_valid;
    logic       out_stall;
    logic [2:0] token_kind;
    logic [7:0] operand_char;
    logic [2:0] status;
    logic       last_of_run;

    // Predictor state
    op_t ops [STACK_DEPTH];
    int  depth_cnt;
    bit  in_quote;
    bit  opnd_open;
    bit  amp_pending;
    bit  bar_pending;
    bit  err_latched;

    token_t     step_toks[$];
    token_t     tokens_due[$];
    logic [7:0] query_bytes[$];

    bit tx_idle_en;
    bit rx_idle_en;
    bit hold_tgl;
    bit hold_ack;
    int hold_left;
    int rx_burst;
    int cycle_count;
    int mismatches;
    int tokens_seen;
    int bytes_sent;
    int queries_sent;
    int error_dones;

    boolean_query_infix_to_postfix_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_code    (char_code),
        .end_of_expr  (end_of_expr),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_kind   (token_kind),
        .operand_char (operand_char),
        .status       (status),
        .last_of_run  (last_of_run)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void clear_model();
        foreach (ops[i])
            ops[i] = OP_PAREN;
        depth_cnt   = 1;
        in_quote    = 1'b0;
        opnd_open   = 1'b0;
        amp_pending = 1'b0;
        bar_pending = 1'b0;
        err_latched = 1'b0;
    endfunction

    function automatic void put_tok(kind_t k, logic [7:0] c, status_t s);
        token_t t;
        t.kind = k;
        t.ch   = c;
        t.st   = s;
        t.last = 1'b0;
        step_toks.insert(step_toks.size(), t);
    endfunction

    function automatic void end_operand();
        if (opnd_open)
        begin
            put_tok(K_END, 8'd0, ST_OK);
            opnd_open = 1'b0;
        end
    endfunction

    function automatic bit push_ok(op_t code);
        if (depth_cnt >= STACK_DEPTH)
            return 1'b0;
        ops[depth_cnt] = code;
        depth_cnt++;
        return 1'b1;
    endfunction

    // Pop down to the nearest open parenthesis, emitting operators on the way
    function automatic status_t close_group();
        op_t top;
        end_operand();
        while (depth_cnt > 0)
        begin
            top = ops[depth_cnt - 1];
            depth_cnt--;
            if (top == OP_PAREN)
                return ST_OK;
            put_tok((top == OP_AND) ? K_AND : K_OR, 8'd0, ST_OK);
        end
        return ST_EXTRA_CLOSE;
    endfunction

    function automatic status_t absorb(logic [7:0] c);
        if (in_quote)
        begin
            if (c == CH_QUOTE)
                in_quote = 1'b0;
            else
            begin
                put_tok(K_CHAR, c, ST_OK);
                opnd_open = 1'b1;
            end
            return ST_OK;
        end
        if (amp_pending)
        begin
            if (c != CH_AMP)
                return ST_ILLEGAL;
            amp_pending = 1'b0;
            end_operand();
            return push_ok(OP_AND) ? ST_OK : ST_OVERFLOW;
        end
        if (bar_pending)
        begin
            if (c != CH_BAR)
                return ST_ILLEGAL;
            bar_pending = 1'b0;
            end_operand();
            // stop at an open parenthesis or at an empty stack
            while (depth_cnt > 0 && ops[depth_cnt - 1] != OP_PAREN)
            begin
                put_tok((ops[depth_cnt - 1] == OP_AND) ? K_AND : K_OR, 8'd0, ST_OK);
                depth_cnt--;
            end
            return push_ok(OP_OR) ? ST_OK : ST_OVERFLOW;
        end
        case (c)
            CH_OPEN:  return push_ok(OP_PAREN) ? ST_OK : ST_OVERFLOW;
            CH_CLOSE: return close_group();
            CH_QUOTE:
            begin
                in_quote = 1'b1;
                return ST_OK;
            end
            CH_AMP:
            begin
                amp_pending = 1'b1;
                return ST_OK;
            end
            CH_BAR:
            begin
                bar_pending = 1'b1;
                return ST_OK;
            end
            CH_SPACE: return ST_OK;
            default: ;
        endcase
        if ((c >= CH_OPER_LO_B && c <= CH_OPER_HI_B) ||
            (c >= CH_OPER_LO_A && c <= CH_OPER_HI_A))
        begin
            put_tok(K_CHAR, c, ST_OK);
            opnd_open = 1'b1;
            return ST_OK;
        end
        return ST_ILLEGAL;
    endfunction

    // Apply the implicit outer close parenthesis
    function automatic status_t finish_query();
        status_t st;
        if (in_quote)
            return ST_EXTRA_OPEN;
        if (amp_pending || bar_pending)
            return ST_ILLEGAL;
        st = close_group();
        if (st != ST_OK)
            return st;
        return (depth_cnt != 0) ? ST_EXTRA_OPEN : ST_OK;
    endfunction

    function automatic void predict_tokens(logic [7:0] c, logic eoe);
        status_t st;
        step_toks.delete();
        if (err_latched)
        begin
            if (eoe)
                clear_model();
            return;
        end
        st = absorb(c);
        if (st != ST_OK)
        begin
            put_tok(K_DONE, 8'd0, st);
            error_dones++;
            if (eoe)
                clear_model();
            else
                err_latched = 1'b1;
        end
        else if (eoe)
        begin
            st = finish_query();
            put_tok(K_DONE, 8'd0, st);
            if (st != ST_OK)
                error_dones++;
            clear_model();
        end
        if (step_toks.size() > 0)
            step_toks[step_toks.size() - 1].last = 1'b1;
        foreach (step_toks[i])
            tokens_due.insert(tokens_due.size(), step_toks[i]);
    endfunction

    // ------------------------------------------------------------------
    // Query text generation
    // ------------------------------------------------------------------
    function automatic void add_byte(logic [7:0] c);
        query_bytes.insert(query_bytes.size(), c);
    endfunction

    function automatic logic [7:0] rand_opnd();
        logic [7:0] c;
        do
            c = 8'($urandom_range(CH_OPER_LO_A, CH_OPER_HI_B));
        while (c == CH_AMP || c == CH_OPEN || c == CH_CLOSE);
        return c;
    endfunction

    function automatic logic [7:0] rand_quoted();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_QUOTE);
        return c;
    endfunction

    function automatic void add_term(int lvl);
        int n;
        if (lvl < 3 && $urandom_range(0, 3) == 0)
        begin
            add_byte(CH_OPEN);
            add_expr(lvl + 1);
            add_byte(CH_CLOSE);
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            add_byte(CH_QUOTE);
            n = $urandom_range(0, 3);
            repeat (n)
                add_byte(rand_quoted());
            add_byte(CH_QUOTE);
        end
        else
        begin
            n = $urandom_range(1, 3);
            repeat (n)
                add_byte(rand_opnd());
        end
        if ($urandom_range(0, 3) == 0)
            add_byte(CH_SPACE);
    endfunction

    function automatic void add_expr(int lvl);
        int terms;
        int t;
        terms = $urandom_range(1, 3);
        for (t = 0; t < terms; t++)
        begin
            if (t > 0)
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    add_byte(CH_AMP);
                    add_byte(CH_AMP);
                end
                else
                begin
                    add_byte(CH_BAR);
                    add_byte(CH_BAR);
                end
                if ($urandom_range(0, 3) == 0)
                    add_byte(CH_SPACE);
            end
            add_term(lvl);
        end
    endfunction

    // Damage a well-formed query in one place
    function automatic void break_query();
        int pos;
        pos = $urandom_range(0, query_bytes.size() - 1);
        case ($urandom_range(0, 3))
            0:       query_bytes[pos] = 8'($urandom_range(0, 255));
            1:       query_bytes.delete(pos);
            2:       query_bytes.insert(pos, CH_OPEN);
            default: query_bytes.insert(pos, CH_CLOSE);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender, receiver and checker
    // ------------------------------------------------------------------
    task automatic send_item(logic [7:0] c, logic eoe);
        int gap;
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        char_code   <= c;
        end_of_expr <= eoe;
        do
            @(posedge clk);
        while (in_stall);
        predict_tokens(c, eoe);
        bytes_sent++;
    endtask

    task automatic send_query();
        if (query_bytes.size() == 0)
            add_byte(CH_SPACE);
        foreach (query_bytes[i])
            send_item(query_bytes[i], i == query_bytes.size() - 1);
        queries_sent++;
    endtask

    task automatic send_text(string s);
        int i;
        query_bytes.delete();
        for (i = 0; i < s.len(); i++)
            add_byte(s[i]);
        send_query();
    endtask

    // Drop valid and hold until every expected token is out and the unit settles
    task automatic wait_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (tokens_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic report_mismatch(string what);
        mismatches++;
        $display("[%0t] token %0d: %s", $realtime, tokens_seen, what);
    endtask

    always @(posedge clk)
    begin : drive_out_stall
        logic nxt;
        // A toggle of hold_tgl starts one long hold-off
        if (hold_tgl != hold_ack)
        begin
            hold_ack  = hold_tgl;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            nxt = 1'b1;
            hold_left--;
        end
        else if (!rx_idle_en)
            nxt = 1'b0;
        else if (rx_burst > 0)
        begin
            nxt = 1'b1;
            rx_burst--;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            rx_burst = $urandom_range(0, 9);
            nxt = 1'b1;
        end
        else
            nxt = 1'b0;
        out_stall <= nxt;
    end

    always @(posedge clk)
    begin : check_tokens
        token_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            tokens_seen++;
            if (tokens_due.size() == 0)
                report_mismatch($sformatf("unexpected token kind %0d char %0d status %0d",
                                          token_kind, operand_char, status));
            else
            begin
                want = tokens_due.pop_front();
                if (token_kind !== want.kind)
                    report_mismatch($sformatf("token_kind %0d, expected %0d",
                                              token_kind, want.kind));
                if (operand_char !== want.ch)
                    report_mismatch($sformatf("operand_char %0d, expected %0d",
                                              operand_char, want.ch));
                if (status !== want.st)
                    report_mismatch($sformatf("status %0d, expected %0d", status, want.st));
                if (last_of_run !== want.last)
                    report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                              last_of_run, want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d tokens still due",
                     cycle_count, tokens_due.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        int i;
        // both operators, or popping and, quoted non-operand bytes,
        // space and quote joining one operand, operand code extremes
        send_text("#&&z||(\"~|\" y)&&%");
        // close past the outer group, then or on an empty stack
        send_text("a)||b");
        send_text("))");
        send_text("((a");
        send_text("\"a b");
        send_text("a|");
        send_text(" ");
        // lone ampersand, then bytes dropped until the end flag
        send_text("a&b c");
        send_item(8'hFF, 1'b0);
        send_item(8'h7A, 1'b1);
        send_item(8'h00, 1'b1);
        // fill the operator stack with open parentheses until it overflows
        query_bytes.delete();
        for (i = 0; i < STACK_DEPTH; i++)
            add_byte(CH_OPEN);
        add_byte(8'h78);
        send_query();
    endtask

    task automatic run_random_queries(int byte_budget);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < byte_budget)
        begin
            query_bytes.delete();
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 6))
                    add_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                add_expr(0);
                if ($urandom_range(0, 4) == 0)
                    break_query();
            end
            send_query();
        end
    endtask

    task automatic test_random_queries();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        run_random_queries(30);
    endtask

    // Hold the output off for a long stretch while bytes keep coming
    task automatic test_backpressure();
        hold_tgl = !hold_tgl;
        run_random_queries(15);
    endtask

    task automatic test_steady_flow();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_random_queries(15);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        char_code   = 8'd0;
        end_of_expr = 1'b0;
        tx_idle_en  = 1'b1;
        rx_idle_en  = 1'b1;
        clear_model();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        wait_drain();
        test_random_queries();
        wait_drain();
        test_backpressure();
        wait_drain();
        test_steady_flow();
        wait_drain();

        $display("%0d queries (%0d bytes) sent, %0d tokens checked, %0d mismatches",
                 queries_sent, bytes_sent, tokens_seen, mismatches);
        $display("%0d queries ended with an error status", error_dones);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
